/* rtl/core/sliding_window_median_macros.svh */
// Assertion helpers shared by the median filter RTL.
// Each helper expects the clock aclk and the active-low reset aresetn in scope.
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// Same-cycle check.
`define SWM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check whose consequent is sampled in the next cycle.
`define SWM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/swm_pkg.sv */
package swm_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 7;
    localparam int WINDOW_RESET    = 64;
    localparam int GROUP_SIZE      = 8;

    // Flags a cell shows for its stored sample.
    typedef struct packed {
        logic valid;
        logic above_old;
        logic above_new;
    } cell_state_t;

    // Flags of a cell's content once the oldest sample has been taken out.
    typedef struct packed {
        logic valid;
        logic above_new;
    } cell_shift_t;

endpackage

/* rtl/core/swm_cell.sv */
module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic                          update,
    input  logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] new_sample,
    input  logic signed [SAMPLE_BITS-1:0] old_sample,
    input  logic signed [SAMPLE_BITS-1:0] up_value,
    input  cell_state_t                   up_state,
    input  logic signed [SAMPLE_BITS-1:0] down_dvalue,
    input  cell_shift_t                   down_dstate,
    output logic signed [SAMPLE_BITS-1:0] value,
    output cell_state_t                   state,
    output logic signed [SAMPLE_BITS-1:0] dvalue,
    output cell_shift_t                   dstate
);

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic                          take_up;

    assign value           = value_reg;
    assign state.valid     = valid_reg;
    assign state.above_old = !valid_reg || (value_reg > old_sample);
    assign state.above_new = !valid_reg || (value_reg > new_sample);

    // The removed sample is the highest cell not above the oldest value, so every
    // cell whose upper neighbor lies above it pulls that neighbor down.
    assign take_up          = full && up_state.above_old;
    assign dvalue           = take_up ? up_value : value_reg;
    assign dstate.valid     = take_up ? up_state.valid : valid_reg;
    assign dstate.above_new = take_up ? up_state.above_new : state.above_new;

    always_comb begin
        if (down_dstate.above_new) begin
            value_next = down_dvalue;
            valid_next = down_dstate.valid;
        end else if (dstate.above_new) begin
            value_next = new_sample;
            valid_next = 1'b1;
        end else begin
            value_next = dvalue;
            valid_next = dstate.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= 1'b0;
        end else if (update) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (update) begin
            value_reg <= value_next;
        end
    end

endmodule

/* rtl/core/swm_ring.sv */
`include "sliding_window_median_macros.svh"

module swm_ring
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_BITS-1:0]           cfg_data,
    input  logic                          accept,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] old_sample,
    output logic                          full,
    output logic [CNT_W-1:0]              count
);

    localparam int PTR_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIDE_W    = (CFG_BITS > CNT_W) ? CFG_BITS : CNT_W;
    localparam int WIN_RESET = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic [CNT_W-1:0]              window_reg;
    logic [CNT_W-1:0]              window_next;
    logic [CNT_W-1:0]              count_reg;
    logic [PTR_W-1:0]              ring_reg;
    logic [PTR_W-1:0]              ring_next;
    logic [CNT_W-1:0]              ring_inc;
    logic [WIDE_W-1:0]             cfg_wide;

    assign old_sample = old_reg;
    assign full       = (count_reg == window_reg);
    assign count      = count_reg;

    // A zero length acts as one, anything past the cell count as the cell count.
    always_comb begin
        cfg_wide = WIDE_W'(cfg_data);
        if (cfg_wide == '0) begin
            window_next = CNT_W'(1);
        end else if (cfg_wide > WIDE_W'(MAX_WINDOW)) begin
            window_next = CNT_W'(MAX_WINDOW);
        end else begin
            window_next = cfg_wide[CNT_W-1:0];
        end
    end

    assign ring_inc  = CNT_W'(ring_reg) + CNT_W'(1);
    assign ring_next = (ring_inc >= window_reg) ? '0 : ring_inc[PTR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= CNT_W'(WIN_RESET);
            count_reg  <= '0;
            ring_reg   <= '0;
        end else if (cfg_we) begin
            window_reg <= window_next;
            count_reg  <= '0;
            ring_reg   <= '0;
        end else if (accept) begin
            ring_reg <= ring_next;
            if (count_reg < window_reg) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // The slot written next holds the sample that leaves on the following beat.
    // With a window of one that slot is the one written right now.
    always_ff @(posedge aclk) begin
        if (accept) begin
            mem[ring_reg] <= sample;
            if (ring_next == ring_reg) begin
                old_reg <= sample;
            end else begin
                old_reg <= mem[ring_next];
            end
        end
    end

    `SWM_ASSERT(count_within_window, count_reg <= window_reg, "held count exceeds window")
    `SWM_ASSERT(ring_within_window, CNT_W'(ring_reg) < window_reg, "ring slot past window")
    `SWM_ASSERT_NEXT(count_grows, accept && !cfg_we && (count_reg < window_reg),
        count_reg == $past(count_reg) + CNT_W'(1), "held count did not grow")

endmodule

/* rtl/core/swm_select.sv */
`include "sliding_window_median_macros.svh"

module swm_select
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic signed [SAMPLE_BITS-1:0] cell_values [MAX_WINDOW],
    input  logic [CNT_W-1:0]              count,
    output logic                          ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS:0]   twice_median,
    output logic [CNT_W-1:0]              samples_held
);

    localparam int PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int NGROUPS = (MAX_WINDOW + GROUP_SIZE - 1) / GROUP_SIZE;

    logic                          pend_reg;
    logic                          s1_valid_reg;
    logic                          out_valid_reg;
    logic                          advance;
    logic [CNT_W-1:0]              lo_pos;
    logic [CNT_W-1:0]              hi_pos;
    logic [PTR_W-1:0]              lo_idx;
    logic [PTR_W-1:0]              hi_idx;
    logic signed [SAMPLE_BITS-1:0] lo_grp [NGROUPS];
    logic signed [SAMPLE_BITS-1:0] hi_grp [NGROUPS];
    logic signed [SAMPLE_BITS-1:0] lo_grp_reg [NGROUPS];
    logic signed [SAMPLE_BITS-1:0] hi_grp_reg [NGROUPS];
    logic [CNT_W-1:0]              s1_held_reg;
    logic signed [SAMPLE_BITS-1:0] lo_val;
    logic signed [SAMPLE_BITS-1:0] hi_val;
    logic signed [SAMPLE_BITS:0]   twice_next;
    logic signed [SAMPLE_BITS:0]   twice_reg;
    logic [CNT_W-1:0]              held_reg;

    // The whole pipe moves together whenever the output register can take a beat.
    assign advance      = !out_valid_reg || out_ready;
    assign ready        = advance;
    assign out_valid    = out_valid_reg;
    assign twice_median = twice_reg;
    assign samples_held = held_reg;

    // Lower and upper middle ranks; equal when the count is odd.
    assign lo_pos = (count - CNT_W'(1)) >> 1;
    assign hi_pos = count >> 1;
    assign lo_idx = lo_pos[PTR_W-1:0];
    assign hi_idx = hi_pos[PTR_W-1:0];

    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            lo_grp[g] = '0;
            hi_grp[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < MAX_WINDOW) begin
                    if (PTR_W'(g * GROUP_SIZE + j) == lo_idx) begin
                        lo_grp[g] = lo_grp[g] | cell_values[g * GROUP_SIZE + j];
                    end
                    if (PTR_W'(g * GROUP_SIZE + j) == hi_idx) begin
                        hi_grp[g] = hi_grp[g] | cell_values[g * GROUP_SIZE + j];
                    end
                end
            end
        end
    end

    always_comb begin
        lo_val = '0;
        hi_val = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            lo_val = lo_val | lo_grp_reg[g];
            hi_val = hi_val | hi_grp_reg[g];
        end
        twice_next = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            pend_reg      <= accept;
            s1_valid_reg  <= pend_reg;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lo_grp_reg  <= lo_grp;
            hi_grp_reg  <= hi_grp;
            s1_held_reg <= count;
            twice_reg   <= twice_next;
            held_reg    <= s1_held_reg;
        end
    end

    `SWM_ASSERT(held_nonzero, !out_valid_reg || (held_reg != '0), "result with empty window")
    `SWM_ASSERT(odd_count_even_sum, !(out_valid_reg && held_reg[0]) || !twice_reg[0],
        "odd count gave odd twice median")

endmodule

/* rtl/core/sliding_window_median.sv */
// Channel  | Direction | Beat content (lowest bits first)
// s_       | in        | sample
// m_       | out       | twice_median, samples_held
// cfg_     | in        | window_size
//
// One sample is taken per cycle while no result waits on m_tready.
// The sorted cell row removes the oldest sample and inserts the new one in the
// same update; the median is then picked out over two registered stages.
// Reset and every window_size write empty the window; there is no clearing pass.
// While a result waits on m_tready, s_tready stays low.
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1),
    localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((SAMPLE_BITS + 1 + CNT_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,    // sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,    // twice_median, samples_held
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_data    // window_size
);

    logic                          accept;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] old_sample;
    logic                          full;
    logic [CNT_W-1:0]              count;
    logic signed [SAMPLE_BITS:0]   twice_median;
    logic [CNT_W-1:0]              samples_held;

    logic signed [SAMPLE_BITS-1:0] cell_value  [MAX_WINDOW];
    cell_state_t                   cell_state  [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] cell_dvalue [MAX_WINDOW];
    cell_shift_t                   cell_dstate [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] up_value    [MAX_WINDOW];
    cell_state_t                   up_state    [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] down_dvalue [MAX_WINDOW];
    cell_shift_t                   down_dstate [MAX_WINDOW];

    assign accept    = s_tvalid && s_tready;
    assign sample    = s_tdata[SAMPLE_BITS-1:0];
    assign cfg_ready = 1'b1;

    always_comb begin
        m_tdata = '0;
        m_tdata[SAMPLE_BITS:0] = twice_median;
        m_tdata[SAMPLE_BITS+1 +: CNT_W] = samples_held;
    end

    swm_ring #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .sample     (sample),
        .old_sample (old_sample),
        .full       (full),
        .count      (count)
    );

    // Cells stay sorted from low to high index; empty cells sit at the top
    // and act as larger than any sample.
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        if (i == MAX_WINDOW - 1) begin : g_top
            assign up_value[i] = '0;
            assign up_state[i] = '{valid: 1'b0, above_old: 1'b1, above_new: 1'b1};
        end else begin : g_mid
            assign up_value[i] = cell_value[i+1];
            assign up_state[i] = cell_state[i+1];
        end

        if (i == 0) begin : g_bottom
            assign down_dvalue[i] = '0;
            assign down_dstate[i] = '{valid: 1'b1, above_new: 1'b0};
        end else begin : g_link
            assign down_dvalue[i] = cell_dvalue[i-1];
            assign down_dstate[i] = cell_dstate[i-1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .clear       (cfg_valid),
            .update      (accept),
            .full        (full),
            .new_sample  (sample),
            .old_sample  (old_sample),
            .up_value    (up_value[i]),
            .up_state    (up_state[i]),
            .down_dvalue (down_dvalue[i]),
            .down_dstate (down_dstate[i]),
            .value       (cell_value[i]),
            .state       (cell_state[i]),
            .dvalue      (cell_dvalue[i]),
            .dstate      (cell_dstate[i])
        );
    end

    swm_select #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_select (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .cell_values  (cell_value),
        .count        (count),
        .ready        (s_tready),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .twice_median (twice_median),
        .samples_held (samples_held)
    );

endmodule
